[sv/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg
// shared constants, phase codes and the reservoir test for the triangle
// sampler
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

    // stream payload widths
    localparam int unsigned RAND_W      = 32;
    localparam int unsigned IN_DATA_W   = 128;
    localparam int unsigned OUT_DATA_W  = 40;
    localparam int unsigned ESTIMATE_W  = 32;
    localparam int unsigned STATUS_W    = 2;

    // sample phase codes
    localparam logic [STATUS_W-1:0] PH_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] PH_FIRST  = 2'd1;
    localparam logic [STATUS_W-1:0] PH_WEDGE  = 2'd2;
    localparam logic [STATUS_W-1:0] PH_CLOSED = 2'd3;

    // accept when (r * n) >> 32 is zero; n arrives zero-extended to 64 bits
    function automatic logic reservoir_accept(
        input logic [RAND_W-1:0] r,
        input logic [63:0]       n
    );
        logic [63:0] prod;
        prod = {32'd0, r} * {32'd0, n[31:0]};
        return (r == '0) || (n == '0) ||
               ((n[63:32] == '0) && (prod[63:32] == '0));
    endfunction

endpackage

`default_nettype wire

[sv/tss_fifo.sv]
// ----------------------------------------------------------------------------
// tss_fifo
// two-entry queue between the classify front and the sample back end
// ----------------------------------------------------------------------------
`default_nettype none

module tss_fifo #(
    parameter int unsigned WIDTH = 98
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_ready,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             n_wptr;
    logic             n_rptr;
    logic [1:0]       n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr ^ i_push;
        n_rptr  = r_rptr ^ i_pop;
        n_count = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[sv/tss_front.sv]
// ----------------------------------------------------------------------------
// tss_front
// edge counter and first-edge reservoir test, pushes classified edges
// ----------------------------------------------------------------------------
`default_nettype none

module tss_front #(
    parameter int unsigned NODE_W     = 32,
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [31:0]                  i_node_a,
    input  wire logic [31:0]                  i_node_b,
    input  wire logic [tss_pkg::RAND_W-1:0]   i_rand_first,
    input  wire logic [tss_pkg::RAND_W-1:0]   i_rand_second,
    input  wire logic                         i_last,
    input  wire logic                         i_q_ready,
    output logic                              o_push,
    output logic [2*NODE_W+tss_pkg::RAND_W+1:0] o_entry
);

    // n of the reservoir test, i.e. edges_seen + 1 with saturation
    logic [COUNT_BITS-1:0] r_edge_n;
    logic [COUNT_BITS-1:0] n_edge_n;
    logic                  keep_first;

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    assign keep_first = tss_pkg::reservoir_accept(i_rand_first, 64'(r_edge_n));

    // entry: {last, keep_first, rand_second, node_b, node_a}
    assign o_entry = {i_last, keep_first, i_rand_second,
                      i_node_b[NODE_W-1:0], i_node_a[NODE_W-1:0]};

    always_comb begin
        n_edge_n = r_edge_n;
        if (o_push) begin
            if (i_last) begin
                n_edge_n = COUNT_BITS'(1);
            end else if (r_edge_n != '1) begin
                n_edge_n = r_edge_n + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_n <= COUNT_BITS'(1);
        end else begin
            r_edge_n <= n_edge_n;
        end
    end

endmodule

`default_nettype wire

[sv/tss_back.sv]
// ----------------------------------------------------------------------------
// tss_back
// sample state: first edge, wedge, closure, and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module tss_back #(
    parameter int unsigned NODE_W     = 32,
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_q_valid,
    input  wire logic [2*NODE_W+tss_pkg::RAND_W+1:0]  i_q_entry,
    output logic                                      o_q_pop,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [tss_pkg::STATUS_W-1:0]              o_status,
    output logic                                      o_found,
    output logic [tss_pkg::ESTIMATE_W-1:0]            o_estimate
);

    logic [NODE_W-1:0]           e_a;
    logic [NODE_W-1:0]           e_b;
    logic [tss_pkg::RAND_W-1:0]  e_r2;
    logic                        e_keep;
    logic                        e_last;

    logic [NODE_W-1:0]           r_first_a, n_first_a;
    logic [NODE_W-1:0]           r_first_b, n_first_b;
    logic [NODE_W-1:0]           r_close_a, n_close_a;
    logic [NODE_W-1:0]           r_close_b, n_close_b;
    logic [COUNT_BITS-1:0]       r_adj, n_adj;
    // always sat_inc(r_adj), keeps the add out of the multiply path
    logic [COUNT_BITS-1:0]       r_adj_inc, n_adj_inc;
    logic [COUNT_BITS-1:0]       r_closing, n_closing;
    logic [tss_pkg::STATUS_W-1:0] r_phase, n_phase;

    logic                        r_out_valid;
    logic [tss_pkg::STATUS_W-1:0] r_out_status;
    logic                        r_out_found;
    logic [tss_pkg::ESTIMATE_W-1:0] r_out_est;

    logic                        adj_hit;
    logic                        keep_second;
    logic                        pair_hit;
    logic [COUNT_BITS-1:0]       adj_inc2;
    logic [63:0]                 closing64;
    logic [tss_pkg::ESTIMATE_W-1:0] est_next;

    assign {e_last, e_keep, e_r2, e_b, e_a} = i_q_entry;

    // a non-final edge never waits on the output side
    assign o_q_pop = i_q_valid && (!e_last || !r_out_valid || i_ready);

    assign adj_hit  = (e_a == r_first_a) || (e_b == r_first_a) ||
                      (e_a == r_first_b) || (e_b == r_first_b);
    assign keep_second = tss_pkg::reservoir_accept(e_r2, 64'(r_adj_inc));
    assign pair_hit = ((e_a == r_close_a) && (e_b == r_close_b)) ||
                      ((e_a == r_close_b) && (e_b == r_close_a));
    assign adj_inc2 = (r_adj_inc == '1) ? r_adj_inc : r_adj_inc + COUNT_BITS'(1);

    always_comb begin
        n_first_a = r_first_a;
        n_first_b = r_first_b;
        n_close_a = r_close_a;
        n_close_b = r_close_b;
        n_adj     = r_adj;
        n_adj_inc = r_adj_inc;
        n_closing = r_closing;
        n_phase   = r_phase;
        if (e_keep) begin
            n_first_a = e_a;
            n_first_b = e_b;
            n_adj     = '0;
            n_adj_inc = COUNT_BITS'(1);
            n_phase   = tss_pkg::PH_FIRST;
        end else if (adj_hit) begin
            n_adj     = r_adj_inc;
            n_adj_inc = adj_inc2;
            if (keep_second) begin
                n_closing = '0;
                n_phase   = tss_pkg::PH_WEDGE;
                priority if (e_a == r_first_a) begin
                    n_close_a = e_b;
                    n_close_b = r_first_b;
                end else if (e_a == r_first_b) begin
                    n_close_a = e_b;
                    n_close_b = r_first_a;
                end else if (e_b == r_first_a) begin
                    n_close_a = e_a;
                    n_close_b = r_first_b;
                end else begin
                    n_close_a = e_a;
                    n_close_b = r_first_a;
                end
            end else if ((r_phase == tss_pkg::PH_WEDGE) && pair_hit) begin
                n_closing = adj_inc2;
                n_phase   = tss_pkg::PH_CLOSED;
            end
        end
    end

    // result fields from the state after this edge
    always_comb begin
        closing64 = 64'(n_closing);
        if (n_phase != tss_pkg::PH_CLOSED) begin
            est_next = '0;
        end else if (closing64[63:32] != '0) begin
            est_next = '1;
        end else begin
            est_next = closing64[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_a <= '0;
            r_first_b <= '0;
            r_close_a <= '0;
            r_close_b <= '0;
            r_adj     <= '0;
            r_adj_inc <= COUNT_BITS'(1);
            r_closing <= '0;
            r_phase   <= tss_pkg::PH_NONE;
        end else if (o_q_pop) begin
            if (e_last) begin
                r_first_a <= '0;
                r_first_b <= '0;
                r_close_a <= '0;
                r_close_b <= '0;
                r_adj     <= '0;
                r_adj_inc <= COUNT_BITS'(1);
                r_closing <= '0;
                r_phase   <= tss_pkg::PH_NONE;
            end else begin
                r_first_a <= n_first_a;
                r_first_b <= n_first_b;
                r_close_a <= n_close_a;
                r_close_b <= n_close_b;
                r_adj     <= n_adj;
                r_adj_inc <= n_adj_inc;
                r_closing <= n_closing;
                r_phase   <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop && e_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && e_last) begin
            r_out_status <= n_phase;
            r_out_found  <= (n_phase == tss_pkg::PH_CLOSED);
            r_out_est    <= est_next;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_found    = r_out_found;
    assign o_estimate = r_out_est;

endmodule

`default_nettype wire

[sv/triangle_sample_stream.sv]
// ----------------------------------------------------------------------------
// triangle_sample_stream
// one-pass neighborhood-sampling triangle estimator over an edge stream
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                data / side fields
//  s_axis    in   s_axis_tvalid/tready     tdata: node_a, node_b, rand_first,
//                                          rand_second; tlast: last_edge
//  m_axis    out  m_axis_tvalid/tready     tdata: sample_status, found,
//                                          estimate (one request per stream)
//
//  one edge a cycle sustained unless a last edge stalls; the loop that bounds
//  it is the sample state update in the back end (compares, one 32x32
//  multiply, next-state select); last edge to result: queue, result register
//  the front tests first-edge replacement as the edge arrives, a two-entry
//  queue lets front and back stall apart
//  only a last edge waits on m_axis_tready; others pass through freely
//  synchronous active-low reset clears the counters, phase and valid flags
//
`default_nettype none

module triangle_sample_stream #(
    parameter int unsigned NODE_BITS  = 32,
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] node_a, [63:32] node_b, [95:64] rand_first, [127:96] rand_second
    input  wire logic [tss_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] sample_status, [2] found, [34:3] estimate, [39:35] zero
    output logic [tss_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    // compared node bits; ids on the port are 32 bits wide
    localparam int unsigned NODE_W  = (NODE_BITS < 32) ? NODE_BITS : 32;
    localparam int unsigned ENTRY_W = 2 * NODE_W + tss_pkg::RAND_W + 2;

    logic [31:0]                 node_a;
    logic [31:0]                 node_b;
    logic [tss_pkg::RAND_W-1:0]  rand_first;
    logic [tss_pkg::RAND_W-1:0]  rand_second;

    logic                        q_ready;
    logic                        q_push;
    logic [ENTRY_W-1:0]          q_wdata;
    logic                        q_valid;
    logic [ENTRY_W-1:0]          q_rdata;
    logic                        q_pop;

    logic [tss_pkg::STATUS_W-1:0]   status;
    logic                           found;
    logic [tss_pkg::ESTIMATE_W-1:0] estimate;

    // unpack the edge request
    assign node_a      = s_axis_tdata[31:0];
    assign node_b      = s_axis_tdata[63:32];
    assign rand_first  = s_axis_tdata[95:64];
    assign rand_second = s_axis_tdata[127:96];

    // front: edge count and first-edge reservoir decision
    tss_front #(
        .NODE_W     (NODE_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_node_a      (node_a),
        .i_node_b      (node_b),
        .i_rand_first  (rand_first),
        .i_rand_second (rand_second),
        .i_last        (s_axis_tlast),
        .i_q_ready     (q_ready),
        .o_push        (q_push),
        .o_entry       (q_wdata)
    );

    // queue of classified edges
    tss_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    // back: adjacency, wedge sampling, closure, result register
    tss_back #(
        .NODE_W     (NODE_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_rdata),
        .o_q_pop    (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_status   (status),
        .o_found    (found),
        .o_estimate (estimate)
    );

    // pack the result request, padded to whole bytes
    assign m_axis_tdata = {5'd0, estimate, found, status};

endmodule

`default_nettype wire

[sv/tss_checker.sv]
// ----------------------------------------------------------------------------
// tss_checker
// port-level checks on the triangle sampler result stream
// ----------------------------------------------------------------------------
`default_nettype none

module tss_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [tss_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [tss_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // found flag agrees with the closed status
    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2] == (m_axis_tdata[1:0] == tss_pkg::PH_CLOSED)))
        else $error("found flag disagrees with status");

    // estimate is zero unless the wedge was closed
    a_est_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != tss_pkg::PH_CLOSED)
            |-> (m_axis_tdata[34:3] == '0))
        else $error("estimate nonzero without closure");

    // every stream's first edge is sampled, so a result never reports none
    a_status_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != tss_pkg::PH_NONE)
            && (m_axis_tdata[39:35] == '0))
        else $error("empty sample status or dirty padding");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind triangle_sample_stream tss_checker u_tss_checker (.*);

`default_nettype wire
